// ----- rtl/ugb_pkg.sv -----
// Shared constants, codes and controller/datapath signal groups for the grid broadphase.
package ugb_pkg;

  localparam int CELLS     = 64;
  localparam int ITEMS     = 64;
  localparam int SLOT_BITS = 7;
  localparam int NSLOT     = 4;
  localparam int LIST_W    = NSLOT * SLOT_BITS;
  localparam int CELL_AW   = $clog2(CELLS);
  localparam int ID_W      = $clog2(ITEMS);
  localparam int DIV_W     = 32;
  localparam int Q_W       = DIV_W + 1;
  localparam int CNT_W     = $clog2(DIV_W);

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_MOVE   = 3'd2;
  localparam logic [2:0] OP_QUERY  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ID  = 2'd1;
  localparam logic [1:0] ST_BAD_BOX = 2'd2;
  localparam logic [1:0] ST_BAD_GRD = 2'd3;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_CELL_W   = 3'd2;
  localparam logic [2:0] REG_CELL_H   = 3'd3;
  localparam logic [2:0] REG_CELLS_X  = 3'd4;
  localparam logic [2:0] REG_CELLS_Y  = 3'd5;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [30:0]        cell_width;
    logic [30:0]        cell_height;
    logic [6:0]         cells_x;
    logic [6:0]         cells_y;
  } cfg_t;

  typedef struct packed {
    logic       ready;
    logic       latch;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic       build;
    logic       item_rd;
    logic       load_old;
    logic       wr_item;
    logic       cell_rd;
    logic       cell_wr;
    logic       k_inc;
    logic       apply_set;
    logic       cnt_inc;
    logic       cnt_clr;
    logic       q_setup;
    logic       q_or;
    logic       out_ld;
    logic       out_hit;
    logic [1:0] res_st;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [2:0] op;
    logic       id_bad;
    logic       grid_bad;
    logic       div_fin;
    logic       div_last;
    logic       bad_box;
    logic       same_list;
    logic       slot_zero;
    logic       slot_big;
    logic       k_last;
    logic       q_empty;
    logic       q_last;
    logic       acc_zero;
    logic       acc_one;
    logic       out_free;
  } stat_t;

endpackage

// ----- rtl/ugb_if.sv -----
// Request and result channel interfaces of the grid broadphase.
interface ugb_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [15:0]        item_id;
  logic signed [31:0] min_x;
  logic signed [31:0] min_y;
  logic signed [31:0] max_x;
  logic signed [31:0] max_y;
  modport source(output valid, op, item_id, min_x, min_y, max_x, max_y, input ready);
  modport sink(input valid, op, item_id, min_x, min_y, max_x, max_y, output ready);
endinterface

interface ugb_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  found_id;
  logic        found;
  logic        last;
  logic [1:0]  status;
  logic [31:0] moves_done;
  modport source(output valid, found_id, found, last, status, moves_done, input ready);
  modport sink(input valid, found_id, found, last, status, moves_done, output ready);
endinterface

// ----- rtl/ugb_dp.sv -----
// Datapath: request registers, shared divider, cell list builder, memories and result register.
module ugb_dp import ugb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  cmd_t       cmd,
  output stat_t      stat,
  ugb_in_if.sink     in_ch,
  ugb_out_if.source  out_ch
);

  function automatic logic [ID_W-1:0] lowest(input logic [ITEMS-1:0] v);
    logic [ID_W-1:0] r;
    r = '0;
    for (int i = ITEMS - 1; i >= 0; i--) begin
      if (v[i]) r = ID_W'(i);
    end
    return r;
  endfunction

  logic [2:0]         op_r;
  logic [15:0]        id_r;
  logic signed [31:0] mnx, mny, mxx, mxy;
  logic [ID_W-1:0]    idx;

  logic [1:0]             j;
  logic signed [Q_W-1:0]  qv [NSLOT];
  logic [DIV_W-1:0]       dq;
  logic [30:0]            drem;
  logic [30:0]            dsz;
  logic                   dneg;
  logic [CNT_W-1:0]       dcnt;

  logic [LIST_W-1:0]  newlist;
  logic               bad_box;
  logic [LIST_W-1:0]  alist;
  logic [1:0]         k;

  logic [LIST_W-1:0]  item_mem [ITEMS];
  logic [ITEMS-1:0]   item_vld;
  logic [LIST_W-1:0]  item_q;
  logic               item_qv;
  logic [ITEMS-1:0]   cell_mem [CELLS];
  logic [CELLS-1:0]   cell_vld;
  logic [ITEMS-1:0]   cell_q;
  logic               cell_qv;

  logic [CELL_AW-1:0] qx, qy, qx0, qx1, qy1;
  logic               qempty;
  logic [ITEMS-1:0]   acc;
  logic [31:0]        cnt;
  logic               out_valid;

  assign idx = id_r[ID_W-1:0];
  assign in_ch.ready = cmd.ready;

  // Grid size check.
  logic [13:0] ncell;
  assign ncell = cfg.cells_x * cfg.cells_y;

  // Divider operand selection.
  logic signed [31:0] coord, orig;
  logic [30:0]        size;
  logic signed [32:0] diff;
  logic [DIV_W-1:0]   mag;
  always_comb begin
    unique case (j)
      2'd0:    coord = mnx;
      2'd1:    coord = mny;
      2'd2:    coord = mxx;
      default: coord = mxy;
    endcase
    orig = j[0] ? cfg.origin_y : cfg.origin_x;
    size = j[0] ? cfg.cell_height : cfg.cell_width;
    if (size == '0) size = 31'd1;
    diff = {coord[31], coord} - {orig[31], orig};
    mag  = diff[32] ? DIV_W'(-diff) : DIV_W'(diff);
  end

  logic [31:0] trial_in;
  logic [32:0] trial;
  assign trial_in = {drem, dq[DIV_W-1]};
  assign trial    = {1'b0, trial_in} - {2'b0, dsz};

  // Cell list of a box.
  logic signed [Q_W-1:0] x0, y0, x1, y1, cxs, cys;
  logic                  inv, oor;
  logic [6:0]            dx, dy;
  logic [13:0]           area;
  logic [LIST_W-1:0]     lst;
  logic [2:0]            n;
  logic [7:0]            row;
  logic [14:0]           cell_no;
  assign x0  = qv[0];
  assign y0  = qv[1];
  assign x1  = qv[2];
  assign y1  = qv[3];
  assign cxs = Q_W'({1'b0, cfg.cells_x});
  assign cys = Q_W'({1'b0, cfg.cells_y});

  always_comb begin
    inv  = (x1 < x0) || (y1 < y0);
    oor  = (x0 < 0) || (y0 < 0) || (x1 >= cxs) || (y1 >= cys);
    dx   = 7'({1'b0, x1[5:0]} - {1'b0, x0[5:0]} + 7'd1);
    dy   = 7'({1'b0, y1[5:0]} - {1'b0, y0[5:0]} + 7'd1);
    area = dx * dy;
    lst  = '0;
    n    = '0;
    row  = '0;
    cell_no = '0;
    for (int yy = 0; yy < NSLOT; yy++) begin
      for (int xx = 0; xx < NSLOT; xx++) begin
        if (7'(yy) < dy && 7'(xx) < dx && n < 3'(NSLOT)) begin
          row  = 8'({2'b0, y0[5:0]} + 8'(yy));
          cell_no = 15'(row * cfg.cells_x) + 15'(x0[5:0]) + 15'(xx) + 15'd1;
          lst[n*SLOT_BITS +: SLOT_BITS] = cell_no[SLOT_BITS-1:0];
          n = n + 3'd1;
        end
      end
    end
  end

  // Query clamping.
  logic signed [Q_W-1:0] x0c, y0c, x1c, y1c;
  always_comb begin
    x0c = (x0 < 0) ? '0 : x0;
    y0c = (y0 < 0) ? '0 : y0;
    x1c = (x1 > cxs - 1) ? cxs - 1 : x1;
    y1c = (y1 > cys - 1) ? cys - 1 : y1;
  end

  logic [SLOT_BITS-1:0] slot;
  logic [CELL_AW-1:0]   ca;
  logic [12:0]          qidx;
  logic [LIST_W-1:0]    item_data;
  logic [ITEMS-1:0]     cdata, bitm;
  assign slot      = alist[k*SLOT_BITS +: SLOT_BITS];
  assign qidx      = 13'(qy * cfg.cells_x) + 13'(qx);
  assign ca        = (op_r == OP_QUERY) ? qidx[CELL_AW-1:0] : CELL_AW'(slot - 1'b1);
  assign item_data = item_qv ? item_q : '0;
  assign cdata     = cell_qv ? cell_q : '0;
  assign bitm      = ITEMS'(1) << idx;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_ch.op;
      id_r <= in_ch.item_id;
      mnx  <= in_ch.min_x;
      mny  <= in_ch.min_y;
      mxx  <= in_ch.max_x;
      mxy  <= in_ch.max_y;
    end
    if (cmd.div_load) begin
      dq   <= mag;
      drem <= '0;
      dneg <= diff[32];
      dsz  <= size;
    end
    if (cmd.div_step) begin
      drem <= trial[32] ? trial_in[30:0] : trial[30:0];
      dq   <= {dq[DIV_W-2:0], ~trial[32]};
    end
    if (cmd.div_store) qv[j] <= dneg ? -Q_W'({1'b0, dq}) : Q_W'({1'b0, dq});
    if (cmd.build) begin
      newlist <= (inv || oor || area > 14'(NSLOT)) ? '0 : lst;
      bad_box <= !inv && (oor || area > 14'(NSLOT));
    end
    if (cmd.load_old) alist <= item_data;
    if (cmd.wr_item) begin
      alist <= newlist;
      item_mem[idx] <= (op_r == OP_REMOVE) ? '0 : newlist;
    end
    if (cmd.item_rd) item_q <= item_mem[idx];
    if (cmd.cell_rd) cell_q <= cell_mem[ca];
    if (cmd.cell_wr) cell_mem[ca] <= cmd.apply_set ? (cdata | bitm) : (cdata & ~bitm);
    if (cmd.q_setup) begin
      qx0    <= x0c[CELL_AW-1:0];
      qx1    <= x1c[CELL_AW-1:0];
      qy1    <= y1c[CELL_AW-1:0];
      qx     <= x0c[CELL_AW-1:0];
      qy     <= y0c[CELL_AW-1:0];
      qempty <= (x0c > x1c) || (y0c > y1c);
    end
    if (cmd.q_or) begin
      if (qx == qx1) begin
        qx <= qx0;
        qy <= qy + 1'b1;
      end else begin
        qx <= qx + 1'b1;
      end
    end
    if (cmd.out_ld || cmd.out_hit) begin
      out_ch.found_id   <= cmd.out_hit ? lowest(acc) : '0;
      out_ch.found      <= cmd.out_hit;
      out_ch.last       <= cmd.out_ld || ((acc & (acc - 1'b1)) == '0);
      out_ch.status     <= cmd.out_hit ? ST_OK : cmd.res_st;
      out_ch.moves_done <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j         <= '0;
      dcnt      <= '0;
      k         <= '0;
      item_qv   <= 1'b0;
      cell_qv   <= 1'b0;
      item_vld  <= '0;
      cell_vld  <= '0;
      acc       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.latch) begin
        j   <= '0;
        acc <= '0;
      end
      if (cmd.div_load) dcnt <= '0;
      if (cmd.div_step) dcnt <= dcnt + 1'b1;
      if (cmd.div_store) j <= j + 1'b1;
      if (cmd.load_old || cmd.wr_item) k <= '0;
      if (cmd.k_inc) k <= k + 1'b1;
      if (cmd.item_rd) item_qv <= item_vld[idx];
      if (cmd.wr_item) item_vld[idx] <= 1'b1;
      if (cmd.cell_rd) cell_qv <= cell_vld[ca];
      if (cmd.cell_wr) cell_vld[ca] <= 1'b1;
      if (cmd.q_or) acc <= acc | cdata;
      if (cmd.out_hit) acc <= acc & (acc - 1'b1);
      if (cmd.cnt_clr) cnt <= '0;
      else if (cmd.cnt_inc) cnt <= cnt + 1'b1;
      if (cmd.out_ld || cmd.out_hit) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid;

  always_comb begin
    stat.in_valid  = in_ch.valid;
    stat.op        = op_r;
    stat.id_bad    = id_r >= 16'(ITEMS);
    stat.grid_bad  = cfg.cells_x == '0 || cfg.cells_y == '0 || ncell > 14'(CELLS)
                     || ncell >= 14'(2 ** SLOT_BITS);
    stat.div_fin   = dcnt == CNT_W'(DIV_W - 1);
    stat.div_last  = j == 2'(NSLOT - 1);
    stat.bad_box   = bad_box;
    stat.same_list = item_data == newlist;
    stat.slot_zero = slot == '0;
    stat.slot_big  = slot > SLOT_BITS'(CELLS);
    stat.k_last    = k == 2'(NSLOT - 1);
    stat.q_empty   = qempty;
    stat.q_last    = (qx == qx1) && (qy == qy1);
    stat.acc_zero  = acc == '0;
    stat.acc_one   = (acc & (acc - 1'b1)) == '0;
    stat.out_free  = !out_valid || out_ch.ready;
  end

  a_cell_wr_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.cell_wr && op_r != OP_QUERY) |-> (slot != '0 && slot <= SLOT_BITS'(CELLS)))
    else $error("cell bitmap written from an empty or out-of-range slot");
  a_last_hit_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_hit && stat.acc_one) |=> (acc == '0))
    else $error("hit set not empty after last hit");
  a_no_result_overrun: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_ld || cmd.out_hit) |-> (!out_valid || out_ch.ready))
    else $error("result register overwritten before it was taken");

endmodule

// ----- rtl/ugb_ctrl.sv -----
// Controller state machine that sequences every request through the datapath.
module ugb_ctrl import ugb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_DIV_LOAD, S_DIV_RUN, S_DIV_NEXT, S_BUILD, S_CHECK,
    S_ITEM_RD, S_ITEM_CMP, S_APPLY_RD, S_APPLY_WR, S_NEXT, S_WR_ITEM,
    S_Q_SETUP, S_Q_RD, S_Q_OR, S_EMIT, S_RESULT
  } state_t;

  state_t     state, state_next;
  logic       aset, aset_next;
  logic [1:0] res_st, res_st_next;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    aset_next   = aset;
    res_st_next = res_st;
    cmd.ready     = state == S_IDLE;
    cmd.apply_set = aset;
    cmd.res_st    = res_st;
    unique case (state)
      S_IDLE: begin
        if (stat.in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        res_st_next = ST_OK;
        state_next  = S_RESULT;
        if (stat.op == OP_CLEAR) begin
          cmd.cnt_clr = 1'b1;
        end else if (stat.op <= OP_MOVE && stat.id_bad) begin
          res_st_next = ST_BAD_ID;
        end else if (stat.op == OP_REMOVE) begin
          state_next = S_ITEM_RD;
        end else if (stat.op <= OP_QUERY) begin
          if (stat.grid_bad) res_st_next = ST_BAD_GRD;
          else state_next = S_DIV_LOAD;
        end
      end
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (stat.div_fin) state_next = S_DIV_NEXT;
      end
      S_DIV_NEXT: begin
        cmd.div_store = 1'b1;
        if (!stat.div_last) state_next = S_DIV_LOAD;
        else if (stat.op == OP_QUERY) state_next = S_Q_SETUP;
        else state_next = S_BUILD;
      end
      S_BUILD: begin
        cmd.build  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.bad_box) begin
          res_st_next = ST_BAD_BOX;
          state_next  = S_RESULT;
        end else if (stat.op == OP_ADD) begin
          state_next = S_WR_ITEM;
        end else begin
          state_next = S_ITEM_RD;
        end
      end
      S_ITEM_RD: begin
        cmd.item_rd = 1'b1;
        state_next  = S_ITEM_CMP;
      end
      S_ITEM_CMP: begin
        // A move that lands on the same cells leaves everything alone.
        if (stat.op == OP_MOVE && stat.same_list) begin
          state_next = S_RESULT;
        end else begin
          cmd.load_old = 1'b1;
          aset_next    = 1'b0;
          state_next   = S_APPLY_RD;
        end
      end
      S_APPLY_RD: begin
        if (stat.slot_zero) begin
          state_next = S_NEXT;
        end else if (stat.slot_big) begin
          cmd.k_inc = 1'b1;
          if (stat.k_last) state_next = S_NEXT;
        end else begin
          cmd.cell_rd = 1'b1;
          state_next  = S_APPLY_WR;
        end
      end
      S_APPLY_WR: begin
        cmd.cell_wr = 1'b1;
        cmd.k_inc   = 1'b1;
        state_next  = stat.k_last ? S_NEXT : S_APPLY_RD;
      end
      S_NEXT: begin
        if (aset) begin
          cmd.cnt_inc = stat.op == OP_MOVE;
          state_next  = S_RESULT;
        end else begin
          state_next = S_WR_ITEM;
        end
      end
      S_WR_ITEM: begin
        cmd.wr_item = 1'b1;
        if (stat.op == OP_REMOVE) begin
          state_next = S_RESULT;
        end else begin
          aset_next  = 1'b1;
          state_next = S_APPLY_RD;
        end
      end
      S_Q_SETUP: begin
        cmd.q_setup = 1'b1;
        state_next  = S_Q_RD;
      end
      S_Q_RD: begin
        if (stat.q_empty) begin
          state_next = S_EMIT;
        end else begin
          cmd.cell_rd = 1'b1;
          state_next  = S_Q_OR;
        end
      end
      S_Q_OR: begin
        cmd.q_or   = 1'b1;
        state_next = stat.q_last ? S_EMIT : S_Q_RD;
      end
      S_EMIT: begin
        cmd.res_st = ST_OK;
        if (stat.out_free) begin
          if (stat.acc_zero) begin
            cmd.out_ld = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.out_hit = 1'b1;
            if (stat.acc_one) state_next = S_IDLE;
          end
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      aset   <= 1'b0;
      res_st <= ST_OK;
    end else begin
      state  <= state_next;
      aset   <= aset_next;
      res_st <= res_st_next;
    end
  end

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> (state == S_DECODE))
    else $error("request accepted outside idle");
  a_divider_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_RUN && stat.div_fin) |=> (state == S_DIV_NEXT))
    else $error("divider did not hand over its quotient");
  a_single_mem_op: assert property (@(posedge clk) disable iff (rst)
    !(cmd.cell_wr && cmd.cell_rd))
    else $error("cell bitmap read and written in one cycle");

endmodule

// ----- rtl/uniform_grid_broadphase_top.sv -----
// Grid broadphase top level: register port, controller and datapath.
// Add sets the item's new cells; a changing move clears the old cells, sets the new ones and
// counts the move; an unchanged move touches no cell; remove clears the item's cells.
// Clear, unknown ops, bad ids and an unusable grid skip the divider; a bad box is found after it.
// A query reports each hit id as its own result, lowest first, or one result with found low if none.
// One request at a time, results may wait; sync reset clears bitmaps, item lists and move count.
module uniform_grid_broadphase_top import ugb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ugb_in_if.sink      in_ch,
  ugb_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x    <= '0;
      cfg.origin_y    <= '0;
      cfg.cell_width  <= 31'd65536;
      cfg.cell_height <= 31'd65536;
      cfg.cells_x     <= 7'd8;
      cfg.cells_y     <= 7'd8;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_ORIGIN_X: cfg.origin_x    <= pwdata;
        REG_ORIGIN_Y: cfg.origin_y    <= pwdata;
        REG_CELL_W:   cfg.cell_width  <= pwdata[30:0];
        REG_CELL_H:   cfg.cell_height <= pwdata[30:0];
        REG_CELLS_X:  cfg.cells_x     <= pwdata[6:0];
        REG_CELLS_Y:  cfg.cells_y     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ORIGIN_X: prdata = cfg.origin_x;
      REG_ORIGIN_Y: prdata = cfg.origin_y;
      REG_CELL_W:   prdata = {1'b0, cfg.cell_width};
      REG_CELL_H:   prdata = {1'b0, cfg.cell_height};
      REG_CELLS_X:  prdata = {25'b0, cfg.cells_x};
      REG_CELLS_Y:  prdata = {25'b0, cfg.cells_y};
      default:      prdata = '0;
    endcase
  end

  ugb_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  ugb_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
